// File: rtl/kaq_pkg.sv
// shared types, constants and register codes for the key autorepeat qualifier
package kaq_pkg;

    // key field and result field widths
    localparam int KEY_BITS         = 8;
    localparam int CNT_W            = 8;
    localparam int CFG_W            = 8;
    localparam int CFG_ADDR_W       = 1;
    localparam int NUM_KEYS_DEFAULT = 8;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 24;

    // key positions in the held mask
    localparam int KEY_LEFT  = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_ROTL  = 2;
    localparam int KEY_ROTR  = 3;
    localparam int KEY_DOWN  = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 8'd16;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 8'd6;

    // per-lane findings for one frame
    typedef struct packed {
        logic pulse;
        logic first;
    } lane_status_t;

    // one result item
    typedef struct packed {
        logic              soft_drop;
        logic signed [1:0] turn;
        logic signed [1:0] move_x;
        logic [KEY_BITS-1:0] first_press_mask;
        logic [KEY_BITS-1:0] repeat_mask;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// File: rtl/kaq_lane.sv
// one key lane: hold counter, repeat phase and pulse decision
module kaq_lane (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic                     held,
    input  logic [kaq_pkg::CFG_W-1:0] repeat_delay,
    input  logic [kaq_pkg::CFG_W-1:0] repeat_interval,
    output kaq_pkg::lane_status_t    status
);
    import kaq_pkg::*;

    logic             held_before_reg, held_before_next;
    logic [CNT_W-1:0] hold_count_reg, hold_count_next;
    logic [CNT_W-1:0] repeat_phase_reg, repeat_phase_next;
    logic [CNT_W:0]   count_inc;
    logic [CNT_W:0]   phase_inc;

    assign count_inc = {1'b0, hold_count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign phase_inc = {1'b0, repeat_phase_reg} + {{CNT_W{1'b0}}, 1'b1};

    // next state and pulse for this frame
    always_comb begin
        held_before_next  = held_before_reg;
        hold_count_next   = hold_count_reg;
        repeat_phase_next = repeat_phase_reg;
        status.pulse      = 1'b0;
        status.first      = 1'b0;
        if (!held) begin
            held_before_next  = 1'b0;
            hold_count_next   = '0;
            repeat_phase_next = '0;
        end else if (!held_before_reg) begin
            held_before_next  = 1'b1;
            hold_count_next   = '0;
            repeat_phase_next = '0;
            status.first      = 1'b1;
            status.pulse      = 1'b1;
        end else if (hold_count_reg < repeat_delay) begin
            hold_count_next = count_inc[CNT_W-1:0];
            if (count_inc == {1'b0, repeat_delay}) begin
                repeat_phase_next = '0;
                status.pulse      = 1'b1;
            end
        end else if (phase_inc >= {1'b0, repeat_interval}) begin
            // phase wraps, autorepeat pulse
            repeat_phase_next = '0;
            status.pulse      = 1'b1;
        end else begin
            repeat_phase_next = phase_inc[CNT_W-1:0];
        end
    end

    // state advances once per accepted frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_before_reg  <= 1'b0;
            hold_count_reg   <= '0;
            repeat_phase_reg <= '0;
        end else if (advance) begin
            held_before_reg  <= held_before_next;
            hold_count_reg   <= hold_count_next;
            repeat_phase_reg <= repeat_phase_next;
        end
    end

endmodule

// File: rtl/kaq_merge.sv
// merging stage: builds masks, lateral step, turn and soft drop from the lanes
module kaq_merge #(
    parameter int NUM_LANES = 8
) (
    input  kaq_pkg::lane_status_t           lanes [NUM_LANES],
    input  logic [kaq_pkg::KEY_BITS-1:0]    keys_held,
    output kaq_pkg::result_t                result
);
    import kaq_pkg::*;

    logic [KEY_BITS-1:0] rep;
    logic [KEY_BITS-1:0] first;

    // gather lane bits, keys without a lane stay quiet
    for (genvar i = 0; i < KEY_BITS; i++) begin : g_bit
        if (i < NUM_LANES) begin : g_lane
            assign rep[i]   = lanes[i].pulse;
            assign first[i] = lanes[i].first;
        end else begin : g_none
            assign rep[i]   = 1'b0;
            assign first[i] = 1'b0;
        end
    end

    // signed differences of two one-bit terms
    always_comb begin
        result.repeat_mask      = rep;
        result.first_press_mask = first;
        unique case ({rep[KEY_RIGHT], rep[KEY_LEFT]})
            2'b10:   result.move_x = 2'sb01;
            2'b01:   result.move_x = 2'sb11;
            default: result.move_x = 2'sb00;
        endcase
        unique case ({first[KEY_ROTR], first[KEY_ROTL]})
            2'b10:   result.turn = 2'sb01;
            2'b01:   result.turn = 2'sb11;
            default: result.turn = 2'sb00;
        endcase
        result.soft_drop = keys_held[KEY_DOWN];
    end

endmodule

// File: rtl/key_autorepeat_qualifier_unit.sv
// top level of the key autorepeat qualifier: config, lanes, merge and output skid
//
// Use: each s_ transaction is one frame tick; s_tdata[7:0] is the held mask of
// the keys (bit 0 left, 1 right, 2 rotate left, 3 rotate right, 4 down).
// Every frame gives exactly one m_ transaction with the repeat mask, the
// first-press mask, the lateral step, the turn and the soft drop level.
// Results are registered in the output register, or in the skid register
// while the receiver stalls. Throughput: one frame per cycle while s_tready
// is high; all key lanes update in parallel in the cycle of acceptance.
// A two-entry output stage (output register plus skid register) holds results
// while the receiver stalls; s_tready drops only once both entries are full,
// and no result is lost or repeated.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 repeat
// delay, 1 repeat interval) at the clock edge; write only while idle.
// Reset (aresetn low, synchronous): all keys read as released, delay 16,
// interval 6, output stage empty.
module key_autorepeat_qualifier_unit #(
    parameter int NUM_KEYS = kaq_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [kaq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [kaq_pkg::CFG_W-1:0]          cfg_wdata,
    // frame input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kaq_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] keys_held
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] repeat_mask, [15:8] first_press_mask, [17:16] move_x,
    // [19:18] turn, [20] soft_drop, [23:21] zero
    output logic [kaq_pkg::M_TDATA_W-1:0]      m_tdata
);
    import kaq_pkg::*;

    // keys past the input mask are never held, so they need no lane
    localparam int NUM_LANES = (NUM_KEYS < KEY_BITS) ? NUM_KEYS : KEY_BITS;

    logic [CFG_W-1:0] repeat_delay_reg;
    logic [CFG_W-1:0] repeat_interval_reg;
    logic             s_accept;
    lane_status_t     lanes [NUM_LANES];
    result_t          result;
    result_t          out_data_reg;
    result_t          skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             out_load;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_delay_reg    <= REPEAT_DELAY_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_wdata;
                REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;

    // key lanes
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        kaq_lane u_lane (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .advance         (s_accept),
            .held            (s_tdata[k]),
            .repeat_delay    (repeat_delay_reg),
            .repeat_interval (repeat_interval_reg),
            .status          (lanes[k])
        );
    end

    // merge lane findings into one result
    kaq_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .lanes     (lanes),
        .keys_held (s_tdata[KEY_BITS-1:0]),
        .result    (result)
    );

    // output register with skid entry
    assign out_load = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                out_data_reg <= result;
            end
        end else if (s_accept) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

    // skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // a frame taken while the output stalls lands in the skid entry
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("frame accepted under stall was not captured");

    // a first press always counts as a repeat pulse
    a_first_in_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_data_reg.first_press_mask
                            & ~out_data_reg.repeat_mask) == '0))
        else $error("first press without repeat pulse");

endmodule

// File: verif/key_autorepeat_checker.sv
// frame predictor and result checker for the key autorepeat qualifier
module key_autorepeat_checker #(
    parameter int NUM_KEYS = kaq_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kaq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kaq_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [kaq_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] keys_held
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] repeat_mask, [15:8] first_press_mask, [17:16] move_x,
    // [19:18] turn, [20] soft_drop, [23:21] zero
    input  logic [kaq_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kaq_pkg::*;

    // predicted key state and register copies
    logic               was_held  [NUM_KEYS];
    logic [CNT_W-1:0]   hold_cnt  [NUM_KEYS];
    logic [CNT_W-1:0]   phase_cnt [NUM_KEYS];
    logic [CFG_W-1:0]   delay_reg;
    logic [CFG_W-1:0]   interval_reg;

    result_t pending_reports[$];
    int      mismatches = 0;
    int      pending_n  = 0;

    assign fail_count     = mismatches;
    assign frames_pending = pending_n;

    // advance every key by one frame and build the report it yields
    function automatic result_t advance_keys(input logic [KEY_BITS-1:0] held_mask);
        result_t             r;
        logic [KEY_BITS-1:0] rep;
        logic [KEY_BITS-1:0] first;
        logic [CNT_W:0]      nxt;
        logic                held;
        rep   = '0;
        first = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            held = 1'b0;
            if (k < KEY_BITS) held = held_mask[k];
            if (!held) begin
                was_held[k]  = 1'b0;
                hold_cnt[k]  = '0;
                phase_cnt[k] = '0;
            end else if (!was_held[k]) begin
                // first held frame always pulses
                was_held[k]  = 1'b1;
                hold_cnt[k]  = '0;
                phase_cnt[k] = '0;
                if (k < KEY_BITS) begin
                    first[k] = 1'b1;
                    rep[k]   = 1'b1;
                end
            end else if (hold_cnt[k] < delay_reg) begin
                // still counting toward the delay
                hold_cnt[k] = hold_cnt[k] + CNT_W'(1);
                if (hold_cnt[k] == delay_reg) begin
                    phase_cnt[k] = '0;
                    if (k < KEY_BITS) rep[k] = 1'b1;
                end
            end else begin
                // saturated: phase wraps at the interval, zero interval acts as one
                nxt = {1'b0, phase_cnt[k]} + (CNT_W + 1)'(1);
                if (nxt >= {1'b0, interval_reg}) nxt = '0;
                phase_cnt[k] = nxt[CNT_W-1:0];
                if (k < KEY_BITS && nxt == '0) rep[k] = 1'b1;
            end
        end
        r.repeat_mask      = rep;
        r.first_press_mask = first;
        r.move_x           = {1'b0, rep[KEY_RIGHT]} - {1'b0, rep[KEY_LEFT]};
        r.turn             = {1'b0, first[KEY_ROTR]} - {1'b0, first[KEY_ROTL]};
        r.soft_drop        = held_mask[KEY_DOWN];
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            pending_reports.delete();
            for (int k = 0; k < NUM_KEYS; k++) begin
                was_held[k]  = 1'b0;
                hold_cnt[k]  = '0;
                phase_cnt[k] = '0;
            end
            delay_reg    = REPEAT_DELAY_RST;
            interval_reg = REPEAT_INTERVAL_RST;
        end else begin
            // compare a result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_reports.size() == 0) begin
                    $display("%0t: result with no frame pending, expected none got %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("repeat_mask", 32'(want.repeat_mask),
                                32'(got.repeat_mask));
                    check_field("first_press_mask", 32'(want.first_press_mask),
                                32'(got.first_press_mask));
                    check_field("move_x", 32'(unsigned'(want.move_x)),
                                32'(unsigned'(got.move_x)));
                    check_field("turn", 32'(unsigned'(want.turn)),
                                32'(unsigned'(got.turn)));
                    check_field("soft_drop", 32'(want.soft_drop), 32'(got.soft_drop));
                    check_field("pad bits", 32'(0),
                                32'(m_tdata[M_TDATA_W-1:RESULT_W]));
                end
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_REPEAT_DELAY:    delay_reg    = cfg_wdata;
                    REG_REPEAT_INTERVAL: interval_reg = cfg_wdata;
                    default: ;
                endcase
            end
            // frame transaction
            if (s_tvalid && s_tready)
                pending_reports.insert(pending_reports.size(),
                                       advance_keys(s_tdata[KEY_BITS-1:0]));
        end
        pending_n = pending_reports.size();
    end

endmodule

// File: verif/key_autorepeat_qualifier_unit_tb.sv
// testbench top for the key autorepeat qualifier: clock, reset, stimulus and verdict
module key_autorepeat_qualifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kaq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_REPEAT_DELAY;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] keys_held
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [7:0] repeat_mask, [15:8] first_press_mask, [17:16] move_x,
    // [19:18] turn, [20] soft_drop, [23:21] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int frames_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int run_left    = 0;

    key_autorepeat_qualifier_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    key_autorepeat_checker repeat_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("key_autorepeat_qualifier_unit_tb: FAIL");
        $finish;
    end

    // receiver stalls, switching between a few patterns
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            mode_left  = $urandom_range(20, 80);
            stall_mode = $urandom_range(0, 3);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (run_left == 0) begin
                    m_tready <= ~m_tready;
                    run_left = $urandom_range(1, 8);
                end else begin
                    run_left--;
                end
            end
        endcase
    end

    // one frame transaction, then maybe a gap once the burst runs out
    task automatic send_frame(input logic [KEY_BITS-1:0] keys);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= keys;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // stop sending and let every predicted result come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [KEY_BITS-1:0] keys;
        logic [CFG_W-1:0]    dly;
        logic [CFG_W-1:0]    ivl;
        int                  len;
        keys = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: all keys at once, each key alone, opposing pairs, high keys
        send_frame(8'h00);
        send_frame(8'hFF);
        send_frame(8'h00);
        send_frame(8'h01);
        send_frame(8'h02);
        send_frame(8'h04);
        send_frame(8'h08);
        send_frame(8'h00);
        send_frame(8'h0C);
        send_frame(8'h03);
        send_frame(8'h10);
        send_frame(8'hE0);

        // zero delay and zero interval: pulse on every held frame
        settle();
        write_reg(REG_REPEAT_DELAY, 8'd0);
        write_reg(REG_REPEAT_INTERVAL, 8'd0);
        repeat (4) send_frame(8'h01);
        send_frame(8'h00);

        // hold a key, then shrink both registers under it
        settle();
        write_reg(REG_REPEAT_DELAY, 8'd3);
        write_reg(REG_REPEAT_INTERVAL, 8'd4);
        repeat (6) send_frame(8'h01);
        settle();
        write_reg(REG_REPEAT_DELAY, 8'd1);
        write_reg(REG_REPEAT_INTERVAL, 8'd1);
        repeat (3) send_frame(8'h01);
        keys = 8'h01;

        // random phases: long holds with sparse toggles plus some noise frames
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                dly = 8'd255;
                ivl = 8'd1;
                len = 265;
            end else if (ph == 1) begin
                dly = 8'd1;
                ivl = 8'd255;
                len = 30;
            end else if (ph == 9) begin
                dly = REPEAT_DELAY_RST;
                ivl = REPEAT_INTERVAL_RST;
                len = 40;
            end else begin
                dly = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 6));
                ivl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 5));
                len = $urandom_range(20, 40);
            end
            settle();
            write_reg(REG_REPEAT_DELAY, dly);
            write_reg(REG_REPEAT_INTERVAL, ivl);
            for (int n = 0; n < len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    keys = 8'($urandom_range(0, 255));
                end else begin
                    for (int b = 0; b < KEY_BITS; b++)
                        if ($urandom_range(0, 9) == 0) keys[b] = ~keys[b];
                end
                // the longest delay needs one key held throughout
                if (ph == 0) keys[KEY_LEFT] = 1'b1;
                send_frame(keys);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("key_autorepeat_qualifier_unit_tb: PASS");
        end else begin
            $display("key_autorepeat_qualifier_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
